// ===== rtl/core/websocket_url_guard_defines.svh =====
// Assertion macros for the WebSocket URL guard.
`ifndef WEBSOCKET_URL_GUARD_DEFINES_SVH
`define WEBSOCKET_URL_GUARD_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define WUG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("websocket_url_guard: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define WUG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("websocket_url_guard: next-cycle check failed");

`endif

// ===== rtl/core/wug_pkg.sv =====
// Shared types, codes, pattern tables and character helpers for the URL guard.
package wug_pkg;

  // Parser phases
  localparam logic [1:0] PH_SCHEME = 2'd0;
  localparam logic [1:0] PH_AUTH   = 2'd1;
  localparam logic [1:0] PH_REST   = 2'd2;
  localparam logic [1:0] PH_DEAD   = 2'd3;

  // Verdict codes
  localparam logic [2:0] VERDICT_OK       = 3'd0;
  localparam logic [2:0] VERDICT_EMPTY    = 3'd1;
  localparam logic [2:0] VERDICT_SCHEME   = 3'd2;
  localparam logic [2:0] VERDICT_CREDS    = 3'd3;
  localparam logic [2:0] VERDICT_LOOPBACK = 3'd4;
  localparam logic [2:0] VERDICT_LINKLOC  = 3'd5;
  localparam logic [2:0] VERDICT_BADCHARS = 3'd6;

  // Host pattern kinds
  localparam logic [1:0] KIND_PREFIX_LOOP = 2'd0;
  localparam logic [1:0] KIND_EXACT_LOOP  = 2'd1;
  localparam logic [1:0] KIND_PREFIX_LINK = 2'd2;

  localparam int unsigned NPAT    = 8;
  localparam int unsigned PAT_MAX = 10;
  localparam logic [3:0]  AUTH_SAT = 4'd10;

  localparam logic [7:0] PAT_TEXT [NPAT][PAT_MAX] = '{
    '{"l", "o", "c", "a", "l", "h", "o", "s", "t", 8'h00},
    '{"1", "2", "7", ".", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"0", ".", "0", ".", "0", ".", "0", 8'h00, 8'h00, 8'h00},
    '{":", ":", "1", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"[", ":", ":", "1", "]", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"1", "6", "9", ".", "2", "5", "4", ".", 8'h00, 8'h00},
    '{"f", "e", "8", "0", ":", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"[", "f", "e", "8", "0", ":", 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [3:0] PAT_LEN [NPAT] = '{
    4'd9, 4'd4, 4'd7, 4'd3, 4'd5, 4'd8, 4'd5, 4'd6
  };

  localparam logic [1:0] PAT_KIND [NPAT] = '{
    KIND_EXACT_LOOP, KIND_PREFIX_LOOP, KIND_EXACT_LOOP, KIND_EXACT_LOOP,
    KIND_PREFIX_LOOP, KIND_PREFIX_LINK, KIND_PREFIX_LINK, KIND_PREFIX_LINK
  };

  // Pattern matcher update for one authority byte
  typedef struct packed {
    logic [NPAT-1:0] alive;
    logic [1:0]      hit;
  } host_upd_t;

  // Character of "ws://" at a position, zero beyond it
  function automatic logic [7:0] ws_char(input logic [2:0] p);
    logic [7:0] r;
    unique case (p)
      3'd0:    r = "w";
      3'd1:    r = "s";
      3'd2:    r = ":";
      3'd3:    r = "/";
      3'd4:    r = "/";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // Character of "wss://" at a position, zero beyond it
  function automatic logic [7:0] wss_char(input logic [2:0] p);
    logic [7:0] r;
    unique case (p)
      3'd0:    r = "w";
      3'd1:    r = "s";
      3'd2:    r = "s";
      3'd3:    r = ":";
      3'd4:    r = "/";
      3'd5:    r = "/";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // Letters, digits and the accepted punctuation
  function automatic logic url_safe(input logic [7:0] c);
    logic r;
    r = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) ||
        ((c >= "0") && (c <= "9")) ||
        (c == ".") || (c == ":") || (c == "/") || (c == "-") || (c == "_") ||
        (c == "?") || (c == "=") || (c == "&") || (c == "@") || (c == "%") ||
        (c == "+") || (c == "#") || (c == "[") || (c == "]");
    return r;
  endfunction

  // Fold ASCII upper case to lower case
  function automatic logic [7:0] fold_lower(input logic [7:0] c);
    return ((c >= "A") && (c <= "Z")) ? (c + 8'd32) : c;
  endfunction

endpackage

// ===== rtl/core/wug_if.sv =====
// Valid/ready channel interfaces for URL bytes and verdicts.
interface wug_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface wug_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] verdict;

  modport source (output valid, output verdict, input ready);
  modport sink   (input valid, input verdict, output ready);
endinterface

// ===== rtl/core/wug_host_match.sv =====
// Parallel matcher of the authority's leading bytes against the host patterns.
module wug_host_match (
  input  logic [7:0]                 ch,
  input  logic [3:0]                 auth_cnt,
  input  logic [wug_pkg::NPAT-1:0]   alive,
  input  logic [1:0]                 hit,
  output wug_pkg::host_upd_t         step,
  output logic                       end_loop
);
  import wug_pkg::*;

  logic [7:0] fc;

  assign fc = fold_lower(ch);

  // Advance every live pattern by one byte
  always_comb begin
    step.alive = alive;
    step.hit   = hit;
    for (int i = 0; i < NPAT; i++) begin
      if (alive[i]) begin
        if (auth_cnt < PAT_LEN[i]) begin
          if (fc != PAT_TEXT[i][auth_cnt]) begin
            step.alive[i] = 1'b0;
          end else if (({1'b0, auth_cnt} + 5'd1 == {1'b0, PAT_LEN[i]}) &&
                       (PAT_KIND[i] != KIND_EXACT_LOOP)) begin
            if (PAT_KIND[i] == KIND_PREFIX_LINK) begin
              step.hit[1] = 1'b1;
            end else begin
              step.hit[0] = 1'b1;
            end
            step.alive[i] = 1'b0;
          end
        end else begin
          // Full exact name followed by a port separator
          if (ch == ":") begin
            step.hit[0] = 1'b1;
          end
          step.alive[i] = 1'b0;
        end
      end
    end
  end

  // At the end of the authority, an exact name matched in full is loopback
  always_comb begin
    end_loop = 1'b0;
    for (int i = 0; i < NPAT; i++) begin
      if (alive[i] && (PAT_KIND[i] == KIND_EXACT_LOOP) && (auth_cnt == PAT_LEN[i])) begin
        end_loop = 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/websocket_url_guard.sv =====
// Top level of the streaming WebSocket URL guard.
//
//   channel   dir  payload        transfer
//   in_chan   in   ch[7:0]        valid && ready, one URL byte; zero ends the URL
//   out_chan  out  verdict[2:0]   valid && ready, one verdict per zero byte
//
// One byte a cycle is taken while in_chan.ready is high, which it drops only
// while a zero byte waits in the input register behind a verdict not yet taken.
// Each byte is registered, then updates the parser state as it leaves the input
// register; a zero byte leaving it writes its verdict to the output register.
// Reset (rst_n low, synchronous) empties both registers and restarts the parser.
`include "websocket_url_guard_defines.svh"

module websocket_url_guard (
  input  logic      clk,
  input  logic      rst_n,
  wug_in_if.sink    in_chan,
  wug_out_if.source out_chan
);
  import wug_pkg::*;

  logic             s1_valid_r, s1_valid_nxt;
  logic [7:0]       s1_ch_r;
  logic             fire;
  logic             is_end;

  logic [1:0]       phase_r, phase_nxt;
  logic [2:0]       spos_r, spos_nxt;
  logic [1:0]       cand_r, cand_nxt;
  logic [3:0]       acnt_r, acnt_nxt;
  logic [NPAT-1:0]  alive_r, alive_nxt;
  logic [1:0]       hit_r, hit_nxt;
  logic             at_r, at_nxt;
  logic             bad_r, bad_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [2:0]       verdict_r, verdict_nxt;

  host_upd_t        host_step;
  logic             end_loop;
  logic [1:0]       hit_end;
  logic [2:0]       final_v;
  logic [1:0]       cand_step;
  logic             scheme_done;

  wug_host_match u_host (
    .ch       (s1_ch_r),
    .auth_cnt (acnt_r),
    .alive    (alive_r),
    .hit      (hit_r),
    .step     (host_step),
    .end_loop (end_loop)
  );

  // Handshake: a zero byte needs room in the output register
  assign is_end         = (s1_ch_r == 8'h00);
  assign fire           = s1_valid_r && (!is_end || !out_valid_r || out_chan.ready);
  assign in_chan.ready  = !s1_valid_r || fire;
  assign out_chan.valid = out_valid_r;
  assign out_chan.verdict = verdict_r;

  // Input register
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_chan.valid && in_chan.ready) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Verdict from the flags, by priority
  always_comb begin
    hit_end = hit_r;
    if (phase_r == PH_AUTH) begin
      hit_end = hit_r | {1'b0, end_loop};
    end
    priority if (at_r) begin
      final_v = VERDICT_CREDS;
    end else if (hit_end[0]) begin
      final_v = VERDICT_LOOPBACK;
    end else if (hit_end[1]) begin
      final_v = VERDICT_LINKLOC;
    end else if (bad_r) begin
      final_v = VERDICT_BADCHARS;
    end else begin
      final_v = VERDICT_OK;
    end
  end

  // Scheme candidates after this byte
  always_comb begin
    cand_step   = 2'b00;
    scheme_done = 1'b0;
    if (cand_r[0] && (spos_r < 3'd5) && (s1_ch_r == ws_char(spos_r))) begin
      cand_step[0] = 1'b1;
      if (spos_r == 3'd4) begin
        scheme_done = 1'b1;
      end
    end
    if (cand_r[1] && (spos_r < 3'd6) && (s1_ch_r == wss_char(spos_r))) begin
      cand_step[1] = 1'b1;
      if (spos_r == 3'd5) begin
        scheme_done = 1'b1;
      end
    end
  end

  // Parser state and result register
  always_comb begin
    phase_nxt     = phase_r;
    spos_nxt      = spos_r;
    cand_nxt      = cand_r;
    acnt_nxt      = acnt_r;
    alive_nxt     = alive_r;
    hit_nxt       = hit_r;
    at_nxt        = at_r;
    bad_nxt       = bad_r;
    out_valid_nxt = out_valid_r;
    verdict_nxt   = verdict_r;

    // Drop a verdict once transferred
    if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (fire) begin
      if (is_end) begin
        out_valid_nxt = 1'b1;
        unique case (phase_r)
          PH_SCHEME: verdict_nxt = (spos_r == 3'd0) ? VERDICT_EMPTY : VERDICT_SCHEME;
          PH_AUTH:   verdict_nxt = (acnt_r == 4'd0) ? VERDICT_SCHEME : final_v;
          PH_REST:   verdict_nxt = final_v;
          default:   verdict_nxt = VERDICT_SCHEME;
        endcase
        // Restart for the next URL
        phase_nxt = PH_SCHEME;
        spos_nxt  = 3'd0;
        cand_nxt  = 2'b11;
        acnt_nxt  = 4'd0;
        alive_nxt = '1;
        hit_nxt   = 2'b00;
        at_nxt    = 1'b0;
        bad_nxt   = 1'b0;
      end else begin
        unique case (phase_r)
          PH_SCHEME: begin
            cand_nxt = cand_step;
            if (scheme_done) begin
              phase_nxt = PH_AUTH;
            end else if (cand_step == 2'b00) begin
              phase_nxt = PH_DEAD;
            end else begin
              spos_nxt = spos_r + 3'd1;
            end
          end
          PH_AUTH: begin
            if ((s1_ch_r == "/") || (s1_ch_r == "?") || (s1_ch_r == "#")) begin
              if (acnt_r == 4'd0) begin
                phase_nxt = PH_DEAD;
              end else begin
                hit_nxt   = hit_r | {1'b0, end_loop};
                alive_nxt = '0;
                phase_nxt = PH_REST;
              end
            end else begin
              bad_nxt   = bad_r | !url_safe(s1_ch_r);
              at_nxt    = at_r | (s1_ch_r == "@");
              alive_nxt = host_step.alive;
              hit_nxt   = host_step.hit;
              if (acnt_r < AUTH_SAT) begin
                acnt_nxt = acnt_r + 4'd1;
              end
            end
          end
          PH_REST: begin
            bad_nxt = bad_r | !url_safe(s1_ch_r);
          end
          default: begin
            // Ignore bytes until the zero byte
          end
        endcase
      end
    end
  end

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_SCHEME;
      spos_r      <= 3'd0;
      cand_r      <= 2'b11;
      acnt_r      <= 4'd0;
      alive_r     <= '1;
      hit_r       <= 2'b00;
      at_r        <= 1'b0;
      bad_r       <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
      spos_r      <= spos_nxt;
      cand_r      <= cand_nxt;
      acnt_r      <= acnt_nxt;
      alive_r     <= alive_nxt;
      hit_r       <= hit_nxt;
      at_r        <= at_nxt;
      bad_r       <= bad_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_ch_r <= in_chan.ch;
    end
    verdict_r <= verdict_nxt;
  end

  // A processed zero byte leaves the parser at its start
  `WUG_ASSERT_NEXT(a_restart, clk, rst_n, fire && is_end,
    (phase_r == PH_SCHEME) && (spos_r == 3'd0) && (cand_r == 2'b11) && (alive_r == '1))

  // Once the authority has closed, no host pattern stays live
  `WUG_ASSERT_NOW(a_rest_no_alive, clk, rst_n, phase_r == PH_REST, alive_r == '0)

  // A zero byte held back by a stalled verdict stays in the input register
  `WUG_ASSERT_NEXT(a_end_held, clk, rst_n,
    s1_valid_r && is_end && out_valid_r && !out_chan.ready,
    s1_valid_r && (s1_ch_r == 8'h00))

endmodule
